@@ hdl/bpl_pkg.sv @@
// shared constants, codes and types of the bit-packed lifo stack
package bpl_pkg;

    localparam int WORD_DEPTH = 1024;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = $clog2(WORD_W);
    localparam int ADDR_W     = $clog2(WORD_DEPTH);
    localparam int CNT_W      = $clog2(WORD_DEPTH + 1);
    localparam int FUNC_W     = 2;
    localparam int COUNT_W    = 6;
    localparam int LAST_BIT   = 31;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef struct packed {
        logic [WORD_W-1:0] partial_word;
        logic [IDX_W-1:0]  bit_index;
        logic [CNT_W-1:0]  word_count;
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic              underflow;
        logic              overflow;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] word;
    } t_store_wr;

endpackage

@@ hdl/bpl_if.sv @@
// valid/ready channel interfaces for the stack's item and result streams
interface bpl_in_if import bpl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] bit_count;
    logic [WORD_W-1:0]  push_value;

    modport source (output valid, func, bit_count, push_value, input ready);
    modport sink   (input valid, func, bit_count, push_value, output ready);
endinterface

interface bpl_out_if import bpl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_value;
    logic              underflow;
    logic              overflow;

    modport source (output valid, read_value, underflow, overflow, input ready);
    modport sink   (input valid, read_value, underflow, overflow, output ready);
endinterface

@@ hdl/bpl_step.sv @@
// next-state and result logic for one push, pop or peek
module bpl_step import bpl_pkg::*; (
    input  t_state             i_state,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [COUNT_W-1:0] i_bit_count,
    input  logic [WORD_W-1:0]  i_push_value,
    input  logic [WORD_W-1:0]  i_top_word,
    output t_state             o_next_state,
    output t_result            o_result,
    output t_store_wr          o_store_wr
);

    t_func                 func;
    logic [COUNT_W-1:0]    n_bits;
    logic [WORD_W:0]       mask_ext;
    logic [WORD_W-1:0]     mask_n;
    logic [COUNT_W-1:0]    idx_sum;
    logic                  word_done;
    logic [2*WORD_W-1:0]   push_shift;
    logic [2*WORD_W-1:0]   push_mask;
    logic [WORD_W-1:0]     push_low;
    logic                  store_full;
    logic                  need_word;
    logic [COUNT_W:0]      pop_sh;
    logic [2*WORD_W-1:0]   pop_shift;
    logic [WORD_W-1:0]     pop_val;
    logic [IDX_W-1:0]      pop_idx;

    assign func       = t_func'(i_func);
    // counts above a full word saturate
    assign n_bits     = i_bit_count[COUNT_W-1] ? COUNT_W'(WORD_W) : i_bit_count;
    assign mask_ext   = ((WORD_W+1)'(1) << n_bits) - (WORD_W+1)'(1);
    assign mask_n     = mask_ext[WORD_W-1:0];

    // push: place the masked value at the bit index, spilling into the next word
    assign idx_sum    = COUNT_W'(i_state.bit_index) + n_bits;
    assign word_done  = idx_sum > COUNT_W'(LAST_BIT);
    assign push_shift = {{WORD_W{1'b0}}, i_push_value & mask_n} << i_state.bit_index;
    assign push_mask  = {{WORD_W{1'b0}}, mask_n} << i_state.bit_index;
    assign push_low   = (i_state.partial_word & ~push_mask[WORD_W-1:0])
                      | push_shift[WORD_W-1:0];
    assign store_full = i_state.word_count >= CNT_W'(WORD_DEPTH);

    // pop/peek: partial word above the top stored word forms one bit stream
    assign need_word  = n_bits > COUNT_W'(i_state.bit_index);
    assign pop_sh     = (COUNT_W+1)'(WORD_W) + (COUNT_W+1)'(i_state.bit_index)
                      - (COUNT_W+1)'(n_bits);
    assign pop_shift  = {i_state.partial_word, i_top_word} >> pop_sh;
    assign pop_val    = pop_shift[WORD_W-1:0] & mask_n;
    assign pop_idx    = i_state.bit_index - IDX_W'(n_bits);

    always_comb begin
        o_next_state = i_state;
        o_result     = '0;
        o_store_wr   = '{en: 1'b0, word: push_low};
        if (n_bits != '0) begin
            unique case (func)
                FUNC_PUSH: begin
                    if (word_done && store_full) begin
                        o_result.overflow = 1'b1;
                    end else if (word_done) begin
                        o_store_wr.en             = 1'b1;
                        o_next_state.partial_word = push_shift[2*WORD_W-1:WORD_W];
                        o_next_state.bit_index    = idx_sum[IDX_W-1:0];
                        o_next_state.word_count   = i_state.word_count + CNT_W'(1);
                    end else begin
                        o_next_state.partial_word = push_low;
                        o_next_state.bit_index    = idx_sum[IDX_W-1:0];
                    end
                end
                FUNC_POP, FUNC_PEEK: begin
                    if (need_word && i_state.word_count == '0) begin
                        o_result.underflow = 1'b1;
                    end else begin
                        o_result.read_value = pop_val;
                        if (func == FUNC_POP) begin
                            o_next_state.bit_index = pop_idx;
                            if (need_word) begin
                                o_next_state.partial_word = i_top_word;
                                o_next_state.word_count   = i_state.word_count - CNT_W'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/bit_packed_lifo_stack_core.sv @@
// top level of the bit-packed lifo stack: state, word store and result register
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  i_in     | in  | valid / ready    | func, bit_count, push_value
//  o_out    | out | valid / ready    | read_value, underflow, overflow
//
// one item per clock while ready; its result is valid the cycle after the transfer
// the word store has one write and one registered read port; the read address
// follows the next word count, so the top stored word is ready for the next item
// a word written in a cycle is forwarded around the store to the next item
// reset clears the stack state and the result valid flag, but not the word store
// a stalled result holds the output register and input ready drops with it
module bit_packed_lifo_stack_core import bpl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bpl_in_if.sink    i_in,
    bpl_out_if.source o_out
);

    // architectural stack state
    t_state            r_state;
    t_state            n_state;
    t_state            step_state;

    // word store with registered read and write forwarding
    logic [WORD_W-1:0] r_store [WORD_DEPTH];
    logic [WORD_W-1:0] r_store_q;
    logic [WORD_W-1:0] r_fwd_word;
    logic              r_fwd;
    logic [WORD_W-1:0] top_word;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  top_pos;
    t_store_wr         step_wr;
    logic              store_we;

    // result register
    t_result           step_res;
    t_result           r_res;
    logic              r_out_valid;

    logic              in_xfer;

    // a new item enters whenever the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    // top stored word: forwarded when it was written last cycle
    assign top_word = r_fwd ? r_fwd_word : r_store_q;

    bpl_step u_step (
        .i_state      (r_state),
        .i_func       (i_in.func),
        .i_bit_count  (i_in.bit_count),
        .i_push_value (i_in.push_value),
        .i_top_word   (top_word),
        .o_next_state (step_state),
        .o_result     (step_res),
        .o_store_wr   (step_wr)
    );

    assign n_state  = in_xfer ? step_state : r_state;
    assign store_we = in_xfer && step_wr.en;

    // prefetch the word that will sit on top after this cycle
    assign top_pos = n_state.word_count - CNT_W'(1);
    assign rd_addr = top_pos[ADDR_W-1:0];

    // store: only written when the count is below depth
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_state.word_count[ADDR_W-1:0]] <= step_wr.word;
        end
        r_store_q  <= r_store[rd_addr];
        r_fwd_word <= step_wr.word;
    end

    // control state and forwarding flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // the write address equals the next read address on every push that stores
            r_fwd   <= store_we;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_res.read_value;
    assign o_out.underflow  = r_res.underflow;
    assign o_out.overflow   = r_res.overflow;

    // word count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.word_count <= CNT_W'(WORD_DEPTH))
        else $error("word count beyond store depth");

    // a rejected item leaves the stack untouched
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (step_res.underflow || step_res.overflow)
        |=> $stable(r_state))
        else $error("rejected item changed the stack");

    // peek never changes the stack
    a_peek_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in.func == FUNC_PEEK)
        |=> $stable(r_state))
        else $error("peek changed the stack");

    // a push that overflows only happens with a full store
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && step_res.overflow |-> r_state.word_count == CNT_W'(WORD_DEPTH))
        else $error("overflow with room in the store");

endmodule

@@ sim/tb_bit_packed_lifo_stack_core.sv @@
// self-checking testbench for the bit-packed lifo stack core with a built-in stack predictor
module tb_bit_packed_lifo_stack_core;
    import bpl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLDOFF_CYCLES = 90;
    localparam int TAIL_CYCLES    = 8;
    localparam int REPORT_MAX     = 10;
    localparam int PHASE_ITEMS    = 180;

    typedef struct packed {
        logic [FUNC_W-1:0]  fn;
        logic [COUNT_W-1:0] nbits;
        logic [WORD_W-1:0]  bits;
    } t_op;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpl_in_if  in_ch();
    bpl_out_if out_ch();

    bit_packed_lifo_stack_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // predicted stack state, advanced on every accepted transfer
    logic [WORD_W-1:0] part_word;
    int                bit_pos;
    int                stored_words;
    logic [WORD_W-1:0] word_mem [WORD_DEPTH];

    t_op     op_queue[$];
    t_result pending_reads[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int          holdoff_asks  = 0;
    int          holdoff_seen  = 0;
    int          holdoff_left  = 0;
    bit          in_took       = 1'b0;

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_reported  = 0;
    int n_pushes    = 0;
    int n_pops      = 0;
    int n_peeks     = 0;
    int n_underflow = 0;
    int n_overflow  = 0;
    int peak_words  = 0;

    // bit-serial view of one operation: pushes pack lsb first, pops unwind msb first
    function automatic t_result apply_bit_op(t_func fn, logic [COUNT_W-1:0] nbits_in,
                                             logic [WORD_W-1:0] bits);
        t_result           res;
        int                n;
        int                k;
        int                idx;
        int                cnt;
        logic [WORD_W-1:0] pw;
        res = '0;
        n = (nbits_in > WORD_W) ? WORD_W : int'(nbits_in);
        if (n == 0)
            return res;
        case (fn)
            FUNC_PUSH: begin
                if (bit_pos + n > LAST_BIT && stored_words >= WORD_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    for (k = 0; k < n; k++) begin
                        part_word[bit_pos] = bits[k];
                        if (bit_pos >= LAST_BIT) begin
                            word_mem[stored_words] = part_word;
                            stored_words++;
                            part_word = '0;
                            bit_pos = 0;
                        end else begin
                            bit_pos++;
                        end
                    end
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                pw  = part_word;
                idx = bit_pos;
                cnt = stored_words;
                if (n > idx && cnt == 0) begin
                    res.underflow = 1'b1;
                end else begin
                    for (k = 0; k < n; k++) begin
                        if (idx == 0) begin
                            cnt--;
                            pw = word_mem[cnt];
                            idx = LAST_BIT;
                        end else begin
                            idx--;
                        end
                        res.read_value[n-1-k] = pw[idx];
                    end
                    if (fn == FUNC_POP) begin
                        part_word    = pw;
                        bit_pos      = idx;
                        stored_words = cnt;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_op(t_func fn, int nbits, logic [WORD_W-1:0] bits);
        t_op op;
        op.fn    = fn;
        op.nbits = nbits[COUNT_W-1:0];
        op.bits  = bits;
        op_queue.push_back(op);
        n_queued++;
    endtask

    function automatic logic [WORD_W-1:0] rand_bits();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return $urandom;
    endfunction

    function automatic int rand_count();
        if ($urandom_range(99) < 6)
            return $urandom_range(0, 63);
        return $urandom_range(1, 32);
    endfunction

    // mixed traffic that hovers near the bottom of the stack
    task automatic queue_random(int items);
        int          i;
        int unsigned r;
        for (i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 46)
                queue_op(FUNC_PUSH, rand_count(), rand_bits());
            else if (r < 80)
                queue_op(FUNC_POP, rand_count(), rand_bits());
            else if (r < 96)
                queue_op(FUNC_PEEK, rand_count(), rand_bits());
            else
                queue_op(FUNC_NONE, rand_count(), rand_bits());
        end
    endtask

    // sender pause: nothing new until every queued item has come back
    task automatic wait_drained();
        while (n_accepted != n_queued || pending_reads.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: holds an offer until it transfers, then pulls the next item
    always @(negedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !in_took)) begin
            if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                op = op_queue.pop_front();
                in_ch.func       <= op.fn;
                in_ch.bit_count  <= op.nbits;
                in_ch.push_value <= op.bits;
                in_ch.valid      <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (holdoff_asks != holdoff_seen) begin
            holdoff_seen = holdoff_asks;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: check results first, then predict the item taken on this edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.read_value = out_ch.read_value;
                got.underflow  = out_ch.underflow;
                got.overflow   = out_ch.overflow;
                if (pending_reads.size() == 0) begin
                    n_errors++;
                    if (n_reported < REPORT_MAX) begin
                        n_reported++;
                        $display("unexpected result: value %h uf %b of %b",
                                 got.read_value, got.underflow, got.overflow);
                    end
                end else begin
                    want = pending_reads.pop_front();
                    n_checked++;
                    if (got.read_value !== want.read_value ||
                        got.underflow !== want.underflow ||
                        got.overflow !== want.overflow) begin
                        n_errors++;
                        if (n_reported < REPORT_MAX) begin
                            n_reported++;
                            $display("mismatch at result %0d: value %h/%h uf %b/%b of %b/%b",
                                     n_checked, want.read_value, got.read_value,
                                     want.underflow, got.underflow,
                                     want.overflow, got.overflow);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                n_accepted++;
                want = apply_bit_op(t_func'(in_ch.func), in_ch.bit_count, in_ch.push_value);
                pending_reads.push_back(want);
                case (t_func'(in_ch.func))
                    FUNC_PUSH: n_pushes++;
                    FUNC_POP:  n_pops++;
                    FUNC_PEEK: n_peeks++;
                    default: ;
                endcase
                if (want.underflow)
                    n_underflow++;
                if (want.overflow)
                    n_overflow++;
                if (stored_words > peak_words)
                    peak_words = stored_words;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        int quiet;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int plan_bits;
        int i;
        int cnt;
        int unsigned r;
        int mark;

        part_word    = '0;
        bit_pos      = 0;
        stored_words = 0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_PUSH;
        in_ch.bit_count  = '0;
        in_ch.push_value = '0;
        out_ch.ready     = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-stack underflow, zero and oversized counts, unused code,
        // word completion from several bit positions and pops across word edges
        queue_op(FUNC_POP,  1,  32'h0);
        queue_op(FUNC_PEEK, 32, 32'h0);
        queue_op(FUNC_PUSH, 0,  32'hFFFF_FFFF);
        queue_op(FUNC_NONE, 5,  32'h0000_1234);
        queue_op(FUNC_PUSH, 1,  32'h0000_0001);
        queue_op(FUNC_PEEK, 1,  32'h0);
        queue_op(FUNC_POP,  2,  32'h0);
        queue_op(FUNC_PUSH, 31, 32'hAAAA_AAAA);
        queue_op(FUNC_PUSH, 32, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH, 63, 32'h5A5A_5A5A);
        queue_op(FUNC_PUSH, 7,  32'h0000_007F);
        queue_op(FUNC_PEEK, 32, 32'h0);
        queue_op(FUNC_POP,  33, 32'h0);
        queue_op(FUNC_POP,  0,  32'h0);
        queue_op(FUNC_NONE, 32, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH, 32, 32'h0000_0000);
        queue_op(FUNC_PUSH, 16, 32'h0000_8001);
        queue_op(FUNC_PEEK, 16, 32'h0);
        queue_op(FUNC_POP,  16, 32'h0);
        queue_op(FUNC_POP,  32, 32'h0);
        queue_op(FUNC_POP,  32, 32'h0);
        queue_op(FUNC_POP,  63, 32'h0);
        queue_op(FUNC_PEEK, 1,  32'h0);
        wait_drained();

        // random traffic under each idling pattern
        send_idle_pct = 0;  stall_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 69; stall_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 0;  stall_pct = 69;
        queue_random(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 21; stall_pct = 21;
        queue_random(PHASE_ITEMS);
        wait_drained();

        // fill the word store to the top, then keep pushing against the full store
        send_idle_pct = 0; stall_pct = 0;
        plan_bits = stored_words * WORD_W + bit_pos;
        mark = n_accepted + 300;
        while (plan_bits < WORD_DEPTH * WORD_W) begin
            r = $urandom_range(99);
            if (r < 4 && plan_bits >= 2 * WORD_W) begin
                cnt = $urandom_range(1, 32);
                queue_op(FUNC_POP, cnt, $urandom);
                plan_bits -= cnt;
            end else if (r < 10) begin
                queue_op(FUNC_PEEK, $urandom_range(1, 32), $urandom);
            end else begin
                cnt = ($urandom_range(99) < 90) ? 32 : $urandom_range(1, 32);
                queue_op(FUNC_PUSH, cnt, $urandom);
                plan_bits += cnt;
            end
        end
        for (i = 0; i < 80; i++) begin
            r = $urandom_range(99);
            if (r < 60)
                queue_op(FUNC_PUSH, $urandom_range(1, 32), $urandom);
            else if (r < 80)
                queue_op(FUNC_PEEK, $urandom_range(1, 32), $urandom);
            else
                queue_op(FUNC_POP, $urandom_range(1, 8), $urandom);
        end
        // long receiver hold-off while the sender keeps offering
        while (n_accepted < mark)
            @(posedge i_clk);
        holdoff_asks++;
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_reads.size() != 0)
            n_errors++;

        $display("run: %0d items (%0d push, %0d pop, %0d peek), %0d results checked",
                 n_accepted, n_pushes, n_pops, n_peeks, n_checked);
        $display("run: %0d underflows, %0d overflows, peak of %0d stored words, %0d errors",
                 n_underflow, n_overflow, peak_words, n_errors);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bpl_pkg.sv
hdl/bpl_if.sv
hdl/bpl_step.sv
hdl/bit_packed_lifo_stack_core.sv
sim/tb_bit_packed_lifo_stack_core.sv
